>>> design/cida_pkg.sv
// ----------------------------------------------------------------------------
// Channel-ID allocator package
// Shared widths, the operation codes, and the transfer and scan structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cida_pkg;

  // Field widths of the command and result transfers
  localparam int unsigned CIDA_OP_W   = 2;
  localparam int unsigned CIDA_ID_W   = 7;
  localparam int unsigned CIDA_TAG_W  = 8;
  // Search hint and scan counter width (holds ID_LIMIT + 1)
  localparam int unsigned CIDA_HINT_W = 8;
  // Width for range checks against the table depth
  localparam int unsigned CIDA_CMP_W  = 11;

  // Parameter defaults
  localparam int unsigned TABLE_DEPTH_DEF = 128;
  localparam int unsigned LOWEST_ID_DEF   = 1;
  localparam int unsigned ID_LIMIT_DEF    = 127;
  localparam int unsigned OWNER_BITS_DEF  = 8;

  typedef enum logic [CIDA_OP_W-1:0] {
    OP_FIND    = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_RELEASE = 2'd2
  } cida_op_e;

  typedef struct packed {
    logic [CIDA_OP_W-1:0]  operation;
    logic [CIDA_ID_W-1:0]  channel_id;
    logic [CIDA_TAG_W-1:0] owner_tag;
  } cida_req_t;

  typedef struct packed {
    logic                 success;
    logic [CIDA_ID_W-1:0] found_id;
  } cida_rsp_t;

  // Scan unit status toward the sequencer
  typedef struct packed {
    logic                   in_range;
    logic                   wrap_ok;
    logic [CIDA_HINT_W-1:0] cnt_inc;
  } cida_scan_t;

endpackage

`default_nettype wire

>>> design/cida_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cida_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/cida_scan.sv
// ----------------------------------------------------------------------------
// Channel-ID allocator scan unit
// Shared bound compare and increment that steps the free-ID search.
// ----------------------------------------------------------------------------
`default_nettype none

module cida_scan import cida_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned LOWEST_ID   = LOWEST_ID_DEF,
  parameter int unsigned ID_LIMIT    = ID_LIMIT_DEF
) (
  input  wire logic [CIDA_HINT_W-1:0] cnt_i,
  input  wire logic [CIDA_HINT_W-1:0] hint_i,
  input  wire logic                   phase_i,
  output cida_scan_t                  scan_o
);

  // Highest ID (exclusive) any scan may reach
  localparam int unsigned UpperBound = (ID_LIMIT < TABLE_DEPTH) ? ID_LIMIT : TABLE_DEPTH;

  logic [CIDA_HINT_W-1:0] wrap_end;
  logic [CIDA_HINT_W-1:0] bound;

  // Upward pass ends at the limit, wrap pass at the hint
  assign wrap_end = (hint_i < CIDA_HINT_W'(UpperBound)) ? hint_i : CIDA_HINT_W'(UpperBound);
  assign bound    = phase_i ? wrap_end : CIDA_HINT_W'(UpperBound);

  assign scan_o.in_range = (cnt_i < bound);
  assign scan_o.wrap_ok  = !phase_i && (hint_i > CIDA_HINT_W'(LOWEST_ID));
  assign scan_o.cnt_inc  = cnt_i + CIDA_HINT_W'(1);

endmodule

`default_nettype wire

>>> design/channel_id_next_fit_allocator.sv
// ----------------------------------------------------------------------------
// Channel-ID next-fit allocator
// Find, acquire and release channel IDs over an occupancy and owner table.
// Reset: a clearing pass frees every entry of the occupancy table, busy stays
//   high meanwhile; the search hint resets to LOWEST_ID.
// Acquire and release: checked in the check state, result strobe registered;
//   illegal or unused commands: strobe in the next cycle. One command at a time.
// Find: one entry per cycle, upward from the hint, then wrapping from LOWEST_ID
//   up to the hint; the first free entry is the result, else a failure.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_id_next_fit_allocator import cida_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned LOWEST_ID   = LOWEST_ID_DEF,
  parameter int unsigned ID_LIMIT    = ID_LIMIT_DEF,
  parameter int unsigned OWNER_BITS  = OWNER_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire cida_req_t req_i,
  output logic           rsp_valid_o,
  output cida_rsp_t      rsp_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned HW = CIDA_HINT_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_CHECK
  } state_e;

  state_e                state_q, state_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [HW-1:0]         cnt_q, cnt_d;
  logic                  phase_q, phase_d;
  logic                  pend_q, pend_d;
  logic [HW-1:0]         pid_q, pid_d;
  logic [HW-1:0]         hint_q, hint_d;
  cida_req_t             req_q, req_d;
  logic                  rsp_vld_q, rsp_vld_d;
  cida_rsp_t             rsp_q, rsp_d;

  logic                  occ_we;
  logic [AW-1:0]         occ_waddr;
  logic [0:0]            occ_wdata;
  logic [0:0]            occ_rdata;
  logic                  own_we;
  logic [OWNER_BITS-1:0] own_wdata;
  logic [OWNER_BITS-1:0] own_rdata;
  logic [AW-1:0]         raddr;

  logic [CIDA_CMP_W-1:0] id_w;
  logic                  id_legal;
  logic [HW-1:0]         id_q_ext;
  cida_scan_t            scan;

  // Occupancy table, cleared by the pass after reset
  cida_ram #(
    .WIDTH (1),
    .DEPTH (TABLE_DEPTH)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .raddr_i (raddr),
    .rdata_o (occ_rdata)
  );

  // Owner table, its read data used only where the entry is occupied
  cida_ram #(
    .WIDTH (OWNER_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_own_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (AW'(req_q.channel_id)),
    .wdata_i (own_wdata),
    .raddr_i (raddr),
    .rdata_o (own_rdata)
  );

  cida_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .LOWEST_ID   (LOWEST_ID),
    .ID_LIMIT    (ID_LIMIT)
  ) u_scan (
    .cnt_i   (cnt_q),
    .hint_i  (hint_q),
    .phase_i (phase_q),
    .scan_o  (scan)
  );

  // Legal ID range check on the incoming command
  assign id_w     = CIDA_CMP_W'(req_i.channel_id);
  assign id_legal = (id_w >= CIDA_CMP_W'(LOWEST_ID)) && (id_w <= CIDA_CMP_W'(ID_LIMIT)) &&
                    (id_w < CIDA_CMP_W'(TABLE_DEPTH));
  assign id_q_ext = HW'(req_q.channel_id);

  assign busy = (state_q != ST_IDLE);

  // Sequencer next state
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    pend_d    = 1'b0;
    pid_d     = pid_q;
    hint_d    = hint_q;
    req_d     = req_q;
    rsp_vld_d = 1'b0;
    rsp_d     = rsp_q;
    occ_we    = 1'b0;
    occ_waddr = AW'(req_q.channel_id);
    occ_wdata = 1'b0;
    own_we    = 1'b0;
    own_wdata = OWNER_BITS'(req_q.owner_tag);
    raddr     = AW'(cnt_q);

    case (state_q)
      ST_CLEAR: begin
        // Sweep the occupancy table to free
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      ST_IDLE: begin
        // Read the addressed entry as the command is taken
        raddr = AW'(req_i.channel_id);
        if (start) begin
          req_d = req_i;
          case (req_i.operation)
            OP_FIND: begin
              cnt_d   = hint_q;
              phase_d = 1'b0;
              state_d = ST_FIND;
            end
            OP_ACQUIRE, OP_RELEASE: begin
              if (id_legal) begin
                state_d = ST_CHECK;
              end else begin
                rsp_vld_d = 1'b1;
                rsp_d     = '0;
              end
            end
            default: begin
              rsp_vld_d = 1'b1;
              rsp_d     = '0;
            end
          endcase
        end
      end

      ST_FIND: begin
        // Check the entry read last cycle, issue the next read
        if (pend_q && !occ_rdata[0]) begin
          rsp_vld_d      = 1'b1;
          rsp_d.success  = 1'b1;
          rsp_d.found_id = CIDA_ID_W'(pid_q);
          state_d        = ST_IDLE;
        end else if (scan.in_range) begin
          pend_d = 1'b1;
          pid_d  = cnt_q;
          cnt_d  = scan.cnt_inc;
        end else if (scan.wrap_ok) begin
          phase_d = 1'b1;
          cnt_d   = HW'(LOWEST_ID);
        end else if (!pend_q) begin
          rsp_vld_d = 1'b1;
          rsp_d     = '0;
          state_d   = ST_IDLE;
        end
      end

      ST_CHECK: begin
        // Update the entry from the table read; acquire moves the hint past the ID, a successful release may lower it
        rsp_vld_d = 1'b1;
        rsp_d     = '0;
        state_d   = ST_IDLE;
        case (req_q.operation)
          OP_ACQUIRE: begin
            hint_d = id_q_ext + HW'(1);
            if (!occ_rdata[0]) begin
              occ_we        = 1'b1;
              occ_wdata     = 1'b1;
              own_we        = 1'b1;
              rsp_d.success = 1'b1;
            end
          end
          OP_RELEASE: begin
            if (occ_rdata[0] && (own_rdata == OWNER_BITS'(req_q.owner_tag))) begin
              occ_we        = 1'b1;
              occ_wdata     = 1'b0;
              rsp_d.success = 1'b1;
              if (hint_q > id_q_ext) begin
                hint_d = id_q_ext;
              end
            end
          end
          default: begin
            rsp_d = '0;
          end
        endcase
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state, hint and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      cnt_q     <= '0;
      phase_q   <= 1'b0;
      pend_q    <= 1'b0;
      pid_q     <= '0;
      hint_q    <= HW'(LOWEST_ID);
      req_q     <= '0;
      rsp_vld_q <= 1'b0;
      rsp_q     <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cnt_q     <= cnt_d;
      phase_q   <= phase_d;
      pend_q    <= pend_d;
      pid_q     <= pid_d;
      hint_q    <= hint_d;
      req_q     <= req_d;
      rsp_vld_q <= rsp_vld_d;
      rsp_q     <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTH
  // A result strobe always leaves the sequencer idle
  a_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (state_q == ST_IDLE))
    else $error("result strobe while sequencer not idle");

  // A failed result carries no ID
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.success) |-> (rsp_o.found_id == '0))
    else $error("failed result with nonzero id");

  // A find transfer enters the scan
  a_find_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.operation == OP_FIND)) |=> (state_q == ST_FIND))
    else $error("find transfer did not start a scan");

  // The scan never writes the occupancy table
  a_find_ro: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIND) |-> !occ_we)
    else $error("table written during find scan");
`endif

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Channel-ID allocator testbench
// Sends find, acquire and release commands through the start/busy handshake,
// predicts every response from a behavioral copy of the occupancy table, the
// owner tags and the next-fit hint, and checks each response strobe in order.
// Random traffic fills the table, holds it full and drains it again, in three
// passes with different amounts of sender idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import cida_pkg::*;

  // Block configuration (package defaults)
  localparam int TBL_DEPTH = TABLE_DEPTH_DEF;
  localparam int ID_LOW    = LOWEST_ID_DEF;
  localparam int ID_HIGH   = ID_LIMIT_DEF;

  // Code outside the operation enum; the block must answer it with a failed result
  localparam logic [CIDA_OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_PER_PASS = 200;
  localparam int DRAIN_CYCLES    = 200;

  typedef enum int {MIX_FILL, MIX_FULL, MIX_DRAIN} traffic_mix_e;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  cida_req_t req_i  = '0;
  logic      rsp_valid_o;
  cida_rsp_t rsp_o;

  cida_req_t cmd_queue[$];
  cida_rsp_t expected_rsp[$];
  int        idle_pct = 0;
  int        fail_count = 0;

  // Allocator state as the block should hold it
  bit          alloc_busy[TBL_DEPTH];
  logic [7:0]  alloc_owner[TBL_DEPTH];
  logic [7:0]  alloc_hint;

  // Table as the command generator will have left it once the queue is done
  bit          plan_busy[TBL_DEPTH];
  logic [7:0]  plan_owner[TBL_DEPTH];

  channel_id_next_fit_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit id_legal(int id);
    return id >= ID_LOW && id <= ID_HIGH && id < TBL_DEPTH;
  endfunction

  // Apply one command to the allocator state and return its response
  function automatic cida_rsp_t allocate_step(cida_req_t cmd);
    int        i;
    int        wrap_end;
    int        id;
    cida_rsp_t rsp;
    rsp = '0;
    id  = cmd.channel_id;
    case (cmd.operation)
      OP_FIND: begin
        for (i = alloc_hint; i < ID_HIGH && i < TBL_DEPTH && !rsp.success; i++) begin
          if (!alloc_busy[i]) begin
            rsp.success  = 1'b1;
            rsp.found_id = 7'(i);
          end
        end
        if (!rsp.success && alloc_hint > ID_LOW) begin
          wrap_end = (alloc_hint > ID_HIGH) ? ID_HIGH : int'(alloc_hint);
          for (i = ID_LOW; i < wrap_end && i < TBL_DEPTH && !rsp.success; i++) begin
            if (!alloc_busy[i]) begin
              rsp.success  = 1'b1;
              rsp.found_id = 7'(i);
            end
          end
        end
      end
      OP_ACQUIRE: begin
        if (id_legal(id)) begin
          alloc_hint = 8'(id + 1);
          if (!alloc_busy[id]) begin
            alloc_busy[id]  = 1'b1;
            alloc_owner[id] = cmd.owner_tag;
            rsp.success     = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        if (id_legal(id) && alloc_busy[id] && alloc_owner[id] == cmd.owner_tag) begin
          if (alloc_hint > id) alloc_hint = 8'(id);
          alloc_busy[id] = 1'b0;
          rsp.success    = 1'b1;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Queue a command and track what it will do to the table
  function automatic void queue_cmd(logic [CIDA_OP_W-1:0] op, int id, int tag);
    cida_req_t cmd;
    cmd.operation  = op;
    cmd.channel_id = 7'(id);
    cmd.owner_tag  = 8'(tag);
    if (id_legal(id)) begin
      if (op == OP_ACQUIRE && !plan_busy[id]) begin
        plan_busy[id]  = 1'b1;
        plan_owner[id] = 8'(tag);
      end else if (op == OP_RELEASE && plan_busy[id] && plan_owner[id] == 8'(tag)) begin
        plan_busy[id] = 1'b0;
      end
    end
    cmd_queue.push_back(cmd);
  endfunction

  // Pick a legal ID whose planned state matches want_busy, or -1 if none
  function automatic int pick_id(bit want_busy);
    int first;
    int k;
    int id;
    first = $urandom_range(ID_HIGH - ID_LOW, 0);
    for (k = 0; k <= ID_HIGH - ID_LOW; k++) begin
      id = ID_LOW + (first + k) % (ID_HIGH - ID_LOW + 1);
      if (plan_busy[id] == want_busy) return id;
    end
    return -1;
  endfunction

  // IDs that find can report, still free in the plan
  function automatic int free_findable();
    int id;
    int n;
    n = 0;
    for (id = ID_LOW; id < ID_HIGH; id++) if (!plan_busy[id]) n++;
    return n;
  endfunction

  function automatic void queue_noise();
    queue_cmd(CIDA_OP_W'($urandom_range(3, 0)), $urandom_range(127, 0),
              $urandom_range(255, 0));
  endfunction

  // Feed commands to the block; a command transfers when start is high and busy low
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else if (!start || !busy) begin
      if (start) expected_rsp.push_back(allocate_step(req_i));
      if (cmd_queue.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
        start <= 1'b1;
        req_i <= cmd_queue.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check each response strobe against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected response: success %0d found_id %0d", rsp_o.success,
               rsp_o.found_id);
        fail_count++;
      end else begin
        if (rsp_o.success !== expected_rsp[0].success) begin
          $error("success: expected %0d, got %0d", expected_rsp[0].success,
                 rsp_o.success);
          fail_count++;
        end
        if (rsp_o.found_id !== expected_rsp[0].found_id) begin
          $error("found_id: expected %0d, got %0d", expected_rsp[0].found_id,
                 rsp_o.found_id);
          fail_count++;
        end
        void'(expected_rsp.pop_front());
      end
    end
  end

  // Stimulus: directed commands, then three passes of random traffic
  initial begin
    traffic_mix_e mix;
    int           pass;
    int           n;
    int           r;
    int           id;
    int           full_left;
    for (id = 0; id < TBL_DEPTH; id++) begin
      alloc_busy[id]  = 1'b0;
      alloc_owner[id] = '0;
      plan_busy[id]   = 1'b0;
      plan_owner[id]  = '0;
    end
    alloc_hint = 8'(ID_LOW);
    mix        = MIX_FILL;
    full_left  = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: edges of the ID range, every operation and the failure cases
    queue_cmd(OP_FIND,    0,   0);
    queue_cmd(OP_ACQUIRE, 0,   'h00);  // below the lowest legal ID
    queue_cmd(OP_ACQUIRE, 1,   'hFF);
    queue_cmd(OP_FIND,    127, 'hFF);
    queue_cmd(OP_ACQUIRE, 1,   'h12);  // already held
    queue_cmd(OP_RELEASE, 1,   'h34);  // wrong owner
    queue_cmd(OP_RELEASE, 2,   'hFF);  // entry is free
    queue_cmd(OP_RELEASE, 0,   'hFF);  // illegal ID
    queue_cmd(OP_ACQUIRE, 127, 'hAA);  // hint moves past the limit
    queue_cmd(OP_FIND,    0,   0);     // upward scan empty, wrap finds one
    queue_cmd(OP_RELEASE, 127, 'hAA);
    queue_cmd(OP_FIND,    0,   0);
    queue_cmd(OP_ACQUIRE, 126, 'h55);
    queue_cmd(OP_FIND,    0,   0);
    queue_cmd(OP_UNUSED,  127, 'hFF);
    queue_cmd(OP_UNUSED,  0,   'h00);
    queue_cmd(OP_RELEASE, 1,   'hFF);
    queue_cmd(OP_RELEASE, 126, 'h55);
    queue_cmd(OP_FIND,    0,   0);

    for (pass = 0; pass < 3; pass++) begin
      idle_pct = (pass == 0) ? 27 : (pass == 1) ? 53 : 0;
      for (n = 0; n < RANDOM_PER_PASS; n++) begin
        r = $urandom_range(99, 0);
        case (mix)
          // Mostly claim free IDs so the table fills up
          MIX_FILL: begin
            if (r < 70) begin
              id = pick_id(1'b0);
              if (id < 0) id = $urandom_range(127, 0);
              queue_cmd(OP_ACQUIRE, id, $urandom_range(255, 0));
            end else if (r < 85) begin
              queue_cmd(OP_FIND, $urandom_range(127, 0), $urandom_range(255, 0));
            end else begin
              queue_noise();
            end
            if (free_findable() == 0) begin
              mix       = MIX_FULL;
              full_left = 8;
            end
          end
          // Table full: find must report nothing
          MIX_FULL: begin
            if (r < 60) queue_cmd(OP_FIND, $urandom_range(127, 0), $urandom_range(255, 0));
            else queue_noise();
            full_left--;
            if (full_left == 0) mix = MIX_DRAIN;
          end
          // Mostly return held IDs, some with the wrong owner
          MIX_DRAIN: begin
            id = pick_id(1'b1);
            if (r < 60 && id >= 0) begin
              queue_cmd(OP_RELEASE, id, int'(plan_owner[id]));
            end else if (r < 70 && id >= 0) begin
              queue_cmd(OP_RELEASE, id,
                        int'(plan_owner[id] ^ 8'($urandom_range(255, 1))));
            end else if (r < 85) begin
              queue_cmd(OP_FIND, $urandom_range(127, 0), $urandom_range(255, 0));
            end else begin
              queue_noise();
            end
            if (free_findable() >= ID_HIGH - ID_LOW - 3) mix = MIX_FILL;
          end
          default: mix = MIX_FILL;
        endcase
      end
      // Let this pass drain before changing the idling
      while (cmd_queue.size() > 0 || start || expected_rsp.size() > 0) @(posedge clk_i);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> channel_id_next_fit_allocator.f
design/cida_pkg.sv
design/cida_ram.sv
design/cida_scan.sv
design/channel_id_next_fit_allocator.sv
verif/testbench.sv
